[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define WRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define WRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/wra_pkg.sv]
package wra_pkg;

  localparam int IDX_W = 14;
  localparam int SMP_W = 8;
  localparam int CNT_W = 10;
  localparam int NAVG_W = 9;

  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] idx;
  } wra_tag_t;

endpackage

[rtl/wra_in_if.sv]
interface wra_in_if;
  logic                        valid;
  logic                        ready;
  logic [wra_pkg::IDX_W-1:0]   point_index;
  logic [wra_pkg::SMP_W-1:0]   sample_a;
  logic [wra_pkg::SMP_W-1:0]   sample_b;
  logic [wra_pkg::CNT_W-1:0]   frames_stored;
  logic [wra_pkg::CNT_W-1:0]   frames_same_settings;

  modport source (output valid, point_index, sample_a, sample_b, frames_stored,
                  frames_same_settings, input ready);
  modport sink (input valid, point_index, sample_a, sample_b, frames_stored,
                frames_same_settings, output ready);
endinterface

[rtl/wra_out_if.sv]
interface wra_out_if;
  logic                        valid;
  logic                        ready;
  logic [wra_pkg::IDX_W-1:0]   out_index;
  logic [wra_pkg::SMP_W-1:0]   average_a;
  logic [wra_pkg::SMP_W-1:0]   average_b;

  modport source (output valid, out_index, average_a, average_b, input ready);
  modport sink (input valid, out_index, average_a, average_b, output ready);
endinterface

[rtl/waveform_running_average_core.sv]
// Channel  | Direction | Carries
// in_ch    | sink      | point_index, sample_a, sample_b, frames_stored, frames_same_settings
// out_ch   | source    | out_index, average_a, average_b
// cfg      | write     | average_count
// One item is accepted per cycle unless the output stalls or its point is still in flight.
// The divider retires one quotient bit per stage.
// An item whose point is still in flight waits until the earlier write to the memory is done.
// A stalled output freezes the whole pipeline. Reset restores average_count to 1.
`include "assert_macros.svh"

module waveform_running_average_core #(
  parameter int POINT_COUNT = 16384,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  wra_in_if.sink                      in_ch,
  wra_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [wra_pkg::NAVG_W-1:0]  cfg_wdata
);

  localparam int VW = 8 + FRAC_BITS;
  localparam int DW = VW + 10;
  localparam int AD = $clog2(POINT_COUNT);

  logic [wra_pkg::NAVG_W-1:0] navg_r;
  logic                       adv;
  logic                       hazard;
  logic                       div_hazard;
  logic                       in_acc;
  logic                       in_range;
  logic [wra_pkg::NAVG_W-1:0] n_in;

  logic                       s1_v_r;
  wra_pkg::wra_tag_t          s1_tag_r;
  logic [wra_pkg::SMP_W-1:0]  s1_sa_r;
  logic [wra_pkg::SMP_W-1:0]  s1_sb_r;
  logic [wra_pkg::NAVG_W-1:0] s1_n_r;
  logic                       s1_byp_r;

  logic [2*VW-1:0]            rd_data;
  logic [VW-1:0]              fx_a;
  logic [VW-1:0]              fx_b;
  logic [VW+8:0]              prod_a;
  logic [VW+8:0]              prod_b;
  logic [DW-1:0]              num_a;
  logic [DW-1:0]              num_b;
  logic [wra_pkg::NAVG_W-1:0] den;

  logic                       dv;
  wra_pkg::wra_tag_t          dtag;
  logic [VW-1:0]              qa;
  logic [VW-1:0]              qb;
  logic                       ram_we;

  logic [VW:0]                rnd_a;
  logic [VW:0]                rnd_b;
  logic [8:0]                 byte_a;
  logic [8:0]                 byte_b;

  logic                       out_valid_r;
  logic [wra_pkg::IDX_W-1:0]  out_idx_r;
  logic [wra_pkg::SMP_W-1:0]  out_a_r;
  logic [wra_pkg::SMP_W-1:0]  out_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      navg_r <= wra_pkg::NAVG_W'(1);
    end else if (cfg_we) begin
      navg_r <= cfg_wdata;
    end
  end

  assign adv      = !out_valid_r || out_ch.ready;
  assign hazard   = div_hazard || (s1_v_r && s1_tag_r.wr &&
                                   s1_tag_r.idx == in_ch.point_index);
  assign in_ch.ready = adv && !hazard;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_range = 17'(in_ch.point_index) < 17'(POINT_COUNT);
  assign n_in     = (wra_pkg::CNT_W'(navg_r) < in_ch.frames_stored) ? navg_r
                    : in_ch.frames_stored[wra_pkg::NAVG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r.wr  <= in_range;
      s1_tag_r.idx <= in_ch.point_index;
      s1_sa_r      <= in_ch.sample_a;
      s1_sb_r      <= in_ch.sample_b;
      s1_n_r       <= n_in;
      s1_byp_r     <= (in_ch.frames_same_settings <= wra_pkg::CNT_W'(1)) ||
                      (n_in <= wra_pkg::NAVG_W'(1));
    end
  end

  wra_ram #(.WIDTH(2 * VW), .DEPTH(POINT_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AD'(dtag.idx)),
    .wdata ({qb, qa}),
    .re    (in_acc && in_range),
    .raddr (AD'(in_ch.point_index)),
    .rdata (rd_data)
  );

  // Weighted sum avg*(N-1) + sample; the bypass case divides the sample by one.
  assign fx_a   = VW'(s1_sa_r) << FRAC_BITS;
  assign fx_b   = VW'(s1_sb_r) << FRAC_BITS;
  assign prod_a = rd_data[VW-1:0] * (s1_n_r - wra_pkg::NAVG_W'(1));
  assign prod_b = rd_data[2*VW-1:VW] * (s1_n_r - wra_pkg::NAVG_W'(1));
  assign num_a  = s1_byp_r ? DW'(fx_a) : DW'(prod_a) + DW'(fx_a);
  assign num_b  = s1_byp_r ? DW'(fx_b) : DW'(prod_b) + DW'(fx_b);
  assign den    = s1_byp_r ? wra_pkg::NAVG_W'(1) : s1_n_r;

  wra_div #(.VW(VW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_v      (s1_v_r),
    .in_tag    (s1_tag_r),
    .in_num_a  (num_a),
    .in_num_b  (num_b),
    .in_den    (den),
    .probe_idx (in_ch.point_index),
    .hazard    (div_hazard),
    .out_v     (dv),
    .out_tag   (dtag),
    .out_q_a   (qa),
    .out_q_b   (qb)
  );

  assign ram_we = adv && dv && dtag.wr;

  assign rnd_a  = {1'b0, qa} + ((VW + 1)'(1) << (FRAC_BITS - 1));
  assign rnd_b  = {1'b0, qb} + ((VW + 1)'(1) << (FRAC_BITS - 1));
  assign byte_a = rnd_a[VW:FRAC_BITS];
  assign byte_b = rnd_b[VW:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx_r <= dtag.idx;
      out_a_r   <= !dtag.wr ? '0 : (byte_a[8] ? 8'hFF : byte_a[7:0]);
      out_b_r   <= !dtag.wr ? '0 : (byte_b[8] ? 8'hFF : byte_b[7:0]);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_index = out_idx_r;
  assign out_ch.average_a = out_a_r;
  assign out_ch.average_b = out_b_r;

  `WRA_ASSERT(a_no_s1_hit,
              !(in_acc && s1_v_r && s1_tag_r.wr && s1_tag_r.idx == in_ch.point_index),
              "item accepted while its point awaits read data")
  `WRA_ASSERT(a_no_accept_stalled, !(in_acc && out_valid_r && !out_ch.ready),
              "item accepted while the pipeline is frozen")
  `WRA_ASSERT_NEXT(a_write_gives_result, ram_we, out_valid_r,
                   "memory write without a result")

endmodule

[rtl/wra_ram.sv]
module wra_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/wra_div.sv]
module wra_div #(
  parameter int VW = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  wra_pkg::wra_tag_t         in_tag,
  input  logic [VW+9:0]             in_num_a,
  input  logic [VW+9:0]             in_num_b,
  input  logic [wra_pkg::NAVG_W-1:0] in_den,
  input  logic [wra_pkg::IDX_W-1:0] probe_idx,
  output logic                      hazard,
  output logic                      out_v,
  output wra_pkg::wra_tag_t         out_tag,
  output logic [VW-1:0]             out_q_a,
  output logic [VW-1:0]             out_q_b
);

  localparam int DW = VW + 10;

  logic [VW:0]                  v_r;
  wra_pkg::wra_tag_t            tag_r [VW+1];
  logic [DW-1:0]                ra_r [VW+1];
  logic [DW-1:0]                rb_r [VW+1];
  logic [wra_pkg::NAVG_W-1:0]   d_r [VW+1];
  logic [VW-1:0]                qa_r [VW+1];
  logic [VW-1:0]                qb_r [VW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[VW-1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
      ra_r[0]  <= in_num_a;
      rb_r[0]  <= in_num_b;
      d_r[0]   <= in_den;
      qa_r[0]  <= '0;
      qb_r[0]  <= '0;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= VW; k++) begin : g_step
    logic [DW-1:0] dsh;
    logic          ge_a;
    logic          ge_b;

    assign dsh  = DW'(d_r[k-1]) << (VW - k);
    assign ge_a = ra_r[k-1] >= dsh;
    assign ge_b = rb_r[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tag_r[k-1];
        d_r[k]   <= d_r[k-1];
        ra_r[k]  <= ge_a ? ra_r[k-1] - dsh : ra_r[k-1];
        rb_r[k]  <= ge_b ? rb_r[k-1] - dsh : rb_r[k-1];
        qa_r[k]  <= qa_r[k-1] | (VW'(ge_a) << (VW - k));
        qb_r[k]  <= qb_r[k-1] | (VW'(ge_b) << (VW - k));
      end
    end
  end

  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k <= VW; k++) begin
      if (v_r[k] && tag_r[k].wr && tag_r[k].idx == probe_idx) begin
        hazard = 1'b1;
      end
    end
  end

  assign out_v   = v_r[VW];
  assign out_tag = tag_r[VW];
  assign out_q_a = qa_r[VW];
  assign out_q_b = qb_r[VW];

endmodule

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPOINTS = 16384;
  localparam int FRAC = 16;
  localparam int AVG_W = 8 + FRAC;
  localparam int PIPE_LAT = FRAC + 12;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [wra_pkg::IDX_W-1:0] idx;
    logic [wra_pkg::SMP_W-1:0] a;
    logic [wra_pkg::SMP_W-1:0] b;
    logic [wra_pkg::CNT_W-1:0] stored;
    logic [wra_pkg::CNT_W-1:0] same;
  } sample_item_t;

  typedef struct packed {
    logic [wra_pkg::IDX_W-1:0] idx;
    logic [wra_pkg::SMP_W-1:0] a;
    logic [wra_pkg::SMP_W-1:0] b;
  } avg_result_t;

  typedef struct {
    sample_item_t item;
    logic         has_known;
    avg_result_t  known;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [wra_pkg::NAVG_W-1:0] cfg_wdata = '0;

  wra_in_if in_bus();
  wra_out_if out_bus();

  waveform_running_average_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus.sink),
    .out_ch(out_bus.source),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [AVG_W-1:0] acc_a [NPOINTS];
  logic [AVG_W-1:0] acc_b [NPOINTS];
  bit written [NPOINTS];
  logic [wra_pkg::NAVG_W-1:0] avg_count;
  avg_result_t pending_avgs[$];
  int error_count = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  int out_stall = 0;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.point_index = '0;
    in_bus.sample_a = '0;
    in_bus.sample_b = '0;
    in_bus.frames_stored = '0;
    in_bus.frames_same_settings = '0;
    out_bus.ready = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  function automatic logic [AVG_W-1:0] blend(input logic [AVG_W-1:0] old_avg,
                                             input logic [wra_pkg::SMP_W-1:0] smp,
                                             input int unsigned n, input bit overwrite);
    logic [63:0] s;
    s = 64'(smp) << FRAC;
    if (overwrite || n <= 1) return s[AVG_W-1:0];
    return AVG_W'((64'(old_avg) * 64'(n - 1) + s) / 64'(n));
  endfunction

  function automatic logic [wra_pkg::SMP_W-1:0] to_byte(input logic [AVG_W-1:0] v);
    logic [63:0] r;
    r = (64'(v) + (64'd1 << (FRAC - 1))) >> FRAC;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic avg_result_t predict_average(input sample_item_t it);
    avg_result_t r;
    int unsigned n;
    bit ow;
    n = (32'(avg_count) < 32'(it.stored)) ? 32'(avg_count) : 32'(it.stored);
    ow = it.same <= 1;
    r.idx = it.idx;
    acc_a[it.idx] = blend(acc_a[it.idx], it.a, n, ow);
    acc_b[it.idx] = blend(acc_b[it.idx], it.b, n, ow);
    written[it.idx] = 1'b1;
    r.a = to_byte(acc_a[it.idx]);
    r.b = to_byte(acc_b[it.idx]);
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_avgs.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          avg_result_t e;
          e = pending_avgs.pop_front();
          if (out_bus.out_index !== e.idx)
            report_mismatch($sformatf("index %0d, expected %0d", out_bus.out_index, e.idx));
          if (out_bus.average_a !== e.a)
            report_mismatch($sformatf("point %0d A %0d, expected %0d", e.idx,
                                      out_bus.average_a, e.a));
          if (out_bus.average_b !== e.b)
            report_mismatch($sformatf("point %0d B %0d, expected %0d", e.idx,
                                      out_bus.average_b, e.b));
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= int'($urandom_range(1, 14)) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input sample_item_t it, input bit has_known, input avg_result_t known);
    avg_result_t p;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.point_index <= it.idx;
    in_bus.sample_a <= it.a;
    in_bus.sample_b <= it.b;
    in_bus.frames_stored <= it.stored;
    in_bus.frames_same_settings <= it.same;
    do @(posedge clk); while (!in_bus.ready);
    p = predict_average(it);
    if (has_known && p !== known)
      report_mismatch($sformatf("prediction disagrees with table at point %0d", it.idx));
    pending_avgs.push_back(p);
  endtask

  task automatic set_average_count(input logic [wra_pkg::NAVG_W-1:0] v);
    in_bus.valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    avg_count = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_item_t mk(input int idx, input int a, input int b,
                                      input int st, input int sm);
    sample_item_t it;
    it.idx = wra_pkg::IDX_W'(idx);
    it.a = wra_pkg::SMP_W'(a);
    it.b = wra_pkg::SMP_W'(b);
    it.stored = wra_pkg::CNT_W'(st);
    it.same = wra_pkg::CNT_W'(sm);
    return it;
  endfunction

  function automatic avg_result_t res(input int idx, input int a, input int b);
    avg_result_t r;
    r.idx = wra_pkg::IDX_W'(idx);
    r.a = wra_pkg::SMP_W'(a);
    r.b = wra_pkg::SMP_W'(b);
    return r;
  endfunction

  task automatic random_item(input int unsigned hot);
    sample_item_t it;
    int k;
    it.idx = wra_pkg::IDX_W'((hot != 0) ? $urandom_range(0, hot - 1)
                                        : $urandom_range(0, NPOINTS - 1));
    if ($urandom_range(0, 9) == 0) it.idx = wra_pkg::IDX_W'($urandom_range(0, NPOINTS - 1));
    it.a = wra_pkg::SMP_W'($urandom_range(0, 255));
    it.b = wra_pkg::SMP_W'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) it.a = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    it.stored = wra_pkg::CNT_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, 20));
    k = int'($urandom_range(0, 9));
    it.same = wra_pkg::CNT_W'((k < 2) ? $urandom_range(0, 1) :
                              (k < 8) ? $urandom_range(2, 20) : $urandom_range(2, 1023));
    if (!written[it.idx]) it.same = wra_pkg::CNT_W'($urandom_range(0, 1));
    send_item(it, 1'b0, '0);
  endtask

  directed_row_t plan[$];
  logic [wra_pkg::NAVG_W-1:0] count_set[] = '{9'd4, 9'd0, 9'd511, 9'd2, 9'd256, 9'd17};

  initial begin
    avg_count = wra_pkg::NAVG_W'(1);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    plan.push_back('{mk(0, 0, 255, 5, 0), 1, res(0, 0, 255)});
    plan.push_back('{mk(16383, 255, 0, 1023, 1), 1, res(16383, 255, 0)});
    plan.push_back('{mk(0, 255, 0, 9, 7), 1, res(0, 255, 0)});
    plan.push_back('{mk(1, 128, 1, 0, 0), 1, res(1, 128, 1)});
    plan.push_back('{mk(1, 16, 200, 0, 1023), 1, res(1, 16, 200)});
    plan.push_back('{mk(10922, 170, 85, 682, 341), 1, res(10922, 170, 85)});
    plan.push_back('{mk(5461, 85, 170, 341, 682), 1, res(5461, 85, 170)});
    foreach (plan[i]) send_item(plan[i].item, plan[i].has_known, plan[i].known);
    plan.delete();

    set_average_count(9'd2);
    plan.push_back('{mk(0, 0, 0, 2, 2), 1, res(0, 128, 0)});
    plan.push_back('{mk(0, 0, 0, 1, 2), 1, res(0, 0, 0)});
    plan.push_back('{mk(16383, 0, 255, 1023, 1023), 0, '0});
    plan.push_back('{mk(1, 17, 0, 2, 3), 0, '0});
    foreach (plan[i]) send_item(plan[i].item, plan[i].has_known, plan[i].known);
    plan.delete();

    set_average_count(9'd511);
    plan.push_back('{mk(16383, 0, 0, 1023, 1023), 0, '0});
    plan.push_back('{mk(10922, 1, 254, 700, 5), 0, '0});
    plan.push_back('{mk(5461, 255, 255, 0, 900), 0, '0});
    foreach (plan[i]) send_item(plan[i].item, plan[i].has_known, plan[i].known);
    plan.delete();

    for (int ph = 0; ph < 6; ph++) begin
      set_average_count(count_set[ph]);
      for (int i = 0; i < 250; i++) random_item(ph[0] ? 32 : 0);
    end
    set_average_count(wra_pkg::NAVG_W'($urandom_range(1, 511)));
    calm = 1'b1;
    for (int i = 0; i < 200; i++) random_item(16);
    in_bus.valid <= 1'b0;

    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/wra_pkg.sv
rtl/wra_in_if.sv
rtl/wra_out_if.sv
rtl/wra_ram.sv
rtl/wra_div.sv
rtl/waveform_running_average_core.sv
bench/tb_top.sv
